// ----- src/buddy_frame_allocator_top_macros.svh -----
// Assertion macros shared by the allocator.
`ifndef BUDDY_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_FRAME_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define BFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bfa_pkg.sv -----
package bfa_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  frame_count;
		logic [31:0] free_address;
	} bfa_req_t;

	typedef struct packed {
		logic [31:0] alloc_address;
		logic        error;
	} bfa_rsp_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DEC,
		ST_SCAN,
		ST_SPLIT,
		ST_DIV,
		ST_FRD,
		ST_FCHK,
		ST_MRD,
		ST_MCHK,
		ST_FIN,
		ST_RESP
	} bfa_state_t;

endpackage

// ----- src/bfa_ram.sv -----
module bfa_ram import bfa_pkg::*; #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/buddy_frame_allocator_top.sv -----
// Buddy allocator over one block of 2**LEVELS frames of FRAME_BYTES bytes each.
// The request channel (in_valid, in_ready, in_data) takes an allocate, which
// rounds its frame count up to a power of two, or a free of a block address.
// Every request gives exactly one transfer on the response channel (out_valid,
// out_ready, out_data): the block address, or an error flag on a failed or
// oversized allocate; a free answers with zeros.
// The frame table lives in a synchronous RAM with registered reads. An allocate
// scans from the wanted level down to level 0 with one table read per cycle,
// at most 2**(LEVELS+1) - 1 reads, then writes one split per cycle. A free
// divides its offset to find the frame and reads the frame's entry, then
// reads and checks the buddy once per merge step, and writes the merged entry.
// One request is in work at a time, and the next can be taken in the cycle
// after the response is registered; the response register lets that happen
// while a response still waits for the receiver.
// After reset the table is cleared one entry a cycle while in_ready stays
// low; base_address resets to zero and may be written via cfg_wr_en and
// cfg_wr_data whenever the block is idle. When the receiver stalls, a
// finished response waits in its state until the register frees.
module buddy_frame_allocator_top import bfa_pkg::*; #(
	parameter int LEVELS      = 7,
	parameter int FRAME_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  bfa_req_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output bfa_rsp_t    out_data,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	localparam int FRAMES = 1 << LEVELS;
	localparam int AW     = LEVELS;
	localparam int LW     = $clog2(LEVELS + 1);
	localparam int EW     = LW + 1;
	localparam logic [63:0] LIMIT  = 64'(FRAMES) * 64'(FRAME_BYTES);
	localparam logic [31:0] FB32   = 32'(FRAME_BYTES);
	localparam logic [LW-1:0] LTOP = LW'(LEVELS);
	localparam int NB = $clog2(LIMIT);
	localparam int FL = $clog2(FRAME_BYTES);
	localparam int SH = NB + FL;
	localparam int PW = 2 * NB + 1;
	localparam logic [63:0] MUL64 =
		((64'd1 << SH) + 64'(FRAME_BYTES) - 64'd1) / 64'(FRAME_BYTES);
	localparam logic [PW-1:0] RECIP = PW'(MUL64);

	bfa_state_t state_q, state_d;

	logic [31:0]   base_q;
	bfa_req_t      req_q;
	bfa_rsp_t      res_q;
	bfa_rsp_t      out_q;
	logic          out_valid_q;
	logic [AW-1:0] clr_q;
	logic [LW-1:0] lvl_q;
	logic [LW-1:0] want_q;
	logic [AW:0]   idx_q;
	logic [AW-1:0] pos_q;
	logic          iss_v_s1;
	logic          iss_last_s1;
	logic [AW-1:0] iss_a_s1;
	logic [NB-1:0] rem_q;
	logic [AW-1:0] frame_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic [7:0]    cnt1;
	logic [3:0]    kbits;
	logic          oversize;
	logic [LW-1:0] want;
	logic [31:0]   offset;
	logic [AW:0]   scan_span;
	logic [AW:0]   idx_next;
	logic          hit;
	logic          scan_end;
	logic          issue;
	logic [AW:0]   split_span;
	logic [PW-1:0] div_prod;
	logic [AW-1:0] msize;
	logic          left;
	logic [AW-1:0] buddy;
	logic          buddy_free;
	logic          out_free;

	bfa_ram #(.WIDTH(EW), .DEPTH(FRAMES)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		cnt1 = (req_q.frame_count == 8'd0) ? 8'd1 : req_q.frame_count;
		kbits = 4'd0;
		for (int i = 0; i < 8; i++) begin
			kbits = kbits + 4'((9'd1 << i) < {1'b0, cnt1});
		end
	end

	assign oversize   = 32'(cnt1) > 32'(FRAMES);
	assign want       = LTOP - LW'(kbits);
	assign offset     = req_q.free_address - base_q;
	assign scan_span  = (AW+1)'(1) << (LTOP - lvl_q);
	assign idx_next   = idx_q + scan_span;
	assign hit        = iss_v_s1 && !ram_rdata[0] && (ram_rdata[EW-1:1] == lvl_q);
	assign scan_end   = iss_v_s1 && (hit || iss_last_s1);
	assign issue      = (state_q == ST_SCAN) && !idx_q[AW] && !scan_end;
	assign split_span = (AW+1)'(1) << (LTOP - (lvl_q + LW'(1)));
	assign div_prod   = PW'(rem_q) * RECIP;
	assign msize      = AW'((AW+1)'(1) << (LTOP - lvl_q));
	assign left       = |(frame_q & (msize | (msize - AW'(1))));
	assign buddy      = left ? (frame_q - msize) : (frame_q + msize);
	assign buddy_free = !ram_rdata[0] && (ram_rdata[EW-1:1] == lvl_q);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		in_ready  = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (req_q.opcode == OP_ALLOC) begin
					state_d = oversize ? ST_RESP : ST_SCAN;
				end else begin
					state_d = (64'(offset) >= LIMIT) ? ST_RESP : ST_DIV;
				end
			end
			ST_SCAN: begin
				ram_re = issue;
				if (iss_v_s1 && hit) begin
					state_d = ST_SPLIT;
				end else if (iss_v_s1 && iss_last_s1 && lvl_q == '0) begin
					state_d = ST_RESP;
				end
			end
			ST_SPLIT: begin
				ram_we = 1'b1;
				if (lvl_q == want_q) begin
					ram_waddr = pos_q;
					ram_wdata = {want_q, 1'b1};
					state_d   = ST_RESP;
				end else begin
					ram_waddr = pos_q + split_span[AW-1:0];
					ram_wdata = {lvl_q + LW'(1), 1'b0};
				end
			end
			ST_DIV: begin
				state_d = ST_FRD;
			end
			ST_FRD: begin
				ram_re    = 1'b1;
				ram_raddr = frame_q;
				state_d   = ST_FCHK;
			end
			ST_FCHK: begin
				state_d = (ram_rdata[EW-1:1] == '0) ? ST_FIN : ST_MRD;
			end
			ST_MRD: begin
				ram_re    = 1'b1;
				ram_raddr = buddy;
				state_d   = ST_MCHK;
			end
			ST_MCHK: begin
				if (buddy_free) begin
					ram_we    = 1'b1;
					ram_waddr = left ? frame_q : buddy;
					state_d   = (lvl_q == LW'(1)) ? ST_FIN : ST_MRD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = frame_q;
				ram_wdata = {lvl_q, 1'b0};
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			iss_v_s1    <= 1'b0;
		end else begin
			state_q  <= state_d;
			iss_v_s1 <= issue;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		iss_a_s1    <= idx_q[AW-1:0];
		iss_last_s1 <= idx_next[AW];
		if (issue) begin
			idx_q <= idx_next;
		end
		if (state_q == ST_RESP && out_free) begin
			out_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				req_q <= in_data;
				res_q <= '0;
			end
			ST_DEC: begin
				res_q.error <= (req_q.opcode == OP_ALLOC) && oversize;
				lvl_q       <= want;
				want_q      <= want;
				idx_q       <= '0;
				rem_q       <= offset[NB-1:0];
			end
			ST_SCAN: begin
				if (iss_v_s1 && hit) begin
					pos_q <= iss_a_s1;
				end else if (iss_v_s1 && iss_last_s1) begin
					if (lvl_q == '0) begin
						res_q.error <= 1'b1;
					end else begin
						lvl_q <= lvl_q - LW'(1);
						idx_q <= '0;
					end
				end
			end
			ST_SPLIT: begin
				if (lvl_q == want_q) begin
					res_q.alloc_address <= base_q + FB32 * 32'(pos_q);
				end else begin
					lvl_q <= lvl_q + LW'(1);
				end
			end
			ST_DIV: begin
				frame_q <= div_prod[SH +: AW];
			end
			ST_FCHK: begin
				lvl_q <= ram_rdata[EW-1:1];
			end
			ST_MCHK: begin
				if (buddy_free) begin
					lvl_q <= lvl_q - LW'(1);
					if (left) begin
						frame_q <= buddy;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`include "buddy_frame_allocator_top_macros.svh"

	`BFA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transfer taken")
	`BFA_ASSERT_NOW(a_err_zero_addr, out_valid && out_data.error, out_data.alloc_address == '0, "error with address")
	`BFA_ASSERT_NOW(a_scan_level, state_q == ST_SCAN, lvl_q <= want_q, "scan above wanted level")
	`BFA_ASSERT_NOW(a_merge_level, state_q == ST_MRD, lvl_q != '0, "merge at level zero")

endmodule

// ----- sim/buddy_frame_allocator_top_test.sv -----
`timescale 1ns / 1ps

module buddy_frame_allocator_top_test import bfa_pkg::*; ();

	localparam int LEVELS = 7;
	localparam int FRAME_BYTES = 4096;
	localparam int FRAMES = 1 << LEVELS;

	class alloc_scoreboard;
		logic [3:0] frame_map [FRAMES];
		logic [31:0] base;
		bfa_rsp_t pending [$];
		int mismatches;

		function void clear_map();
			foreach (frame_map[i]) frame_map[i] = '0;
			base = '0;
		endfunction

		function bit is_free(int idx, int lvl);
			logic [3:0] e;
			e = frame_map[idx & (FRAMES - 1)];
			return (e[0] == 1'b0) && (int'(e[3:1]) == lvl);
		endfunction

		function int first_free(int lvl);
			int span;
			span = 1 << (LEVELS - lvl);
			for (int i = 0; i < FRAMES; i += span)
				if (is_free(i, lvl)) return i;
			return FRAMES;
		endfunction

		function bfa_rsp_t allocate(int count);
			bfa_rsp_t r;
			int k, want, lvl, pos;
			r = '0;
			if (count == 0) count = 1;
			if (count > FRAMES) begin
				r.error = 1'b1;
				return r;
			end
			k = 0;
			while ((1 << k) < count) k++;
			want = LEVELS - k;
			lvl = want;
			pos = first_free(lvl);
			while (pos >= FRAMES) begin
				if (lvl == 0) begin
					r.error = 1'b1;
					return r;
				end
				lvl--;
				pos = first_free(lvl);
			end
			while (lvl < want) begin
				lvl++;
				frame_map[pos] = 4'(lvl << 1);
				frame_map[(pos + (1 << (LEVELS - lvl))) & (FRAMES - 1)] = 4'(lvl << 1);
			end
			frame_map[pos][0] = 1'b1;
			r.alloc_address = base + 32'(FRAME_BYTES) * 32'(pos);
			return r;
		endfunction

		function void release_block(logic [31:0] addr);
			logic [31:0] off;
			int frame, lvl, size, buddy;
			bit left;
			off = addr - base;
			off = off / FRAME_BYTES;
			if (off >= FRAMES) return;
			frame = int'(off);
			frame_map[frame][0] = 1'b0;
			lvl = int'(frame_map[frame][3:1]);
			while (lvl > 0) begin
				size = 1 << (LEVELS - lvl);
				left = (frame % (size << 1)) != 0;
				buddy = left ? ((frame - size) & (FRAMES - 1)) : ((frame + size) & (FRAMES - 1));
				if (!is_free(buddy, lvl)) break;
				frame_map[buddy] = '0;
				frame_map[frame] = '0;
				if (left) frame = buddy;
				lvl--;
			end
			frame_map[frame] = 4'(lvl << 1);
		endfunction

		function void note_request(bfa_req_t q);
			if (q.opcode == OP_ALLOC) pending.push_back(allocate(int'(q.frame_count)));
			else begin
				release_block(q.free_address);
				pending.push_back('0);
			end
		endfunction

		function void check_response(bfa_rsp_t got);
			bfa_rsp_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.alloc_address !== want.alloc_address || got.error !== want.error) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected addr %h err %b, got addr %h err %b",
						want.alloc_address, want.error, got.alloc_address, got.error);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bfa_req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bfa_rsp_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	alloc_scoreboard board;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	buddy_frame_allocator_top #(.LEVELS(LEVELS), .FRAME_BYTES(FRAME_BYTES)) u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	initial board = new();

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_response(out_data);
		end
	end

	// Receiver with random stalls, and some responses taken without any.
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if (gap == 0) out_ready = 1'b1;
			else begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
				out_ready = 1'b1;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_request(bfa_req_t q, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= q;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_request(q);
		@(negedge clk);
	endtask

	task automatic do_alloc(int count, bit no_gap);
		bfa_req_t q;
		q = '0;
		q.opcode = OP_ALLOC;
		q.frame_count = 8'(count);
		q.free_address = $urandom();
		send_request(q, no_gap);
	endtask

	task automatic do_free(logic [31:0] addr, bit no_gap);
		bfa_req_t q;
		q = '0;
		q.opcode = OP_FREE;
		q.frame_count = 8'($urandom());
		q.free_address = addr;
		send_request(q, no_gap);
	endtask

	task automatic drain_and_set_base(logic [31:0] value);
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		board.base = value;
	endtask

	task automatic random_phase(int n);
		logic [31:0] addr;
		int pick, c;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
					: (1 << $urandom_range(0, 4)) - $urandom_range(0, 1);
				do_alloc(c, $urandom_range(0, 3) == 0);
			end else if (pick < 9) begin
				addr = board.base + 32'(FRAME_BYTES) * 32'($urandom_range(0, FRAMES - 1));
				if ($urandom_range(0, 2) == 0) addr = addr + $urandom_range(0, FRAME_BYTES - 1);
				do_free(addr, $urandom_range(0, 3) == 0);
			end else
				do_free($urandom(), 1'b0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		board.clear_map();
		board.mismatches = 0;

		// Directed: extremes, several sizes, oversized, exhaustion, frees and merges.
		do_alloc(0, 1'b1);
		do_alloc(1, 1'b0);
		do_alloc(3, 1'b0);
		do_alloc(64, 1'b0);
		do_alloc(129, 1'b1);
		do_alloc(255, 1'b0);
		do_alloc(128, 1'b0);
		do_free(32'h0000_0000, 1'b0);
		do_free(32'h0000_1000, 1'b0);
		do_free(32'h0000_1000, 1'b0);
		do_free(32'h0000_4fff, 1'b1);
		do_free(32'h0004_0000, 1'b0);
		do_free(32'hffff_ffff, 1'b0);
		do_free(32'h0000_0000, 1'b0);
		do_alloc(128, 1'b0);
		do_alloc(1, 1'b0);
		do_free(32'h0000_0000, 1'b0);
		for (int i = 0; i < 5; i++) do_alloc(32, 1'b1);

		drain_and_set_base(32'hffff_ffff);
		random_phase(200);
		drain_and_set_base(32'hffff_f000);
		do_alloc(128, 1'b0);
		random_phase(200);
		drain_and_set_base(32'h8000_0000);
		random_phase(200);
		drain_and_set_base($urandom());
		random_phase(200);
		drain_and_set_base(32'h0000_0000);
		random_phase(200);

		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
